### hw/rtl/sha1he_pkg.sv
// types, constants and command structures shared by the sha1 hash engine
`default_nettype none
package sha1he_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned LEN_W    = 61;
  localparam int unsigned ROUND_W  = 7;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned BLK_WRDS = 16;
  localparam int unsigned CHAIN_N  = 5;

  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
  localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;

  localparam logic [WORD_W-1:0] H_INIT [CHAIN_N] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_DATA_LAST,
    PH_PAD_EXTRA,
    PH_FINAL
  } phase_t;

  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } rnd_grp_t;

  typedef struct packed {
    logic             write_byte;
    logic             load;
    logic             round;
    rnd_grp_t         grp;
    logic             add;
    logic             pad;
    logic             len_blk;
    logic             emit;
    logic [IDX_W-1:0] emit_idx;
    logic             finish;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_full;
    logic pos_ge56;
  } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/sha1he_ctrl.sv
// controller state machine sequencing byte intake, padding, rounds and digest output
`default_nettype none
module sha1he_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_has_byte,
  input  wire logic                in_last,
  input  wire sha1he_pkg::dp_stat_t stat,
  output sha1he_pkg::dp_cmd_t      cmd,
  output logic                     busy
);
  import sha1he_pkg::*;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic [IDX_W-1:0]     emit_r, emit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_DATA;
      round_r <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      round_r <= round_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    round_nxt = round_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_has_byte && stat.pos_full) begin
            phase_nxt = in_last ? PH_DATA_LAST : PH_DATA;
            state_nxt = ST_LOAD;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_LOAD: begin
        round_nxt = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        round_nxt = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        unique case (phase_r)
          PH_DATA:      state_nxt = ST_IDLE;
          PH_DATA_LAST: state_nxt = ST_PAD;
          PH_PAD_EXTRA: state_nxt = ST_LEN;
          PH_FINAL:     state_nxt = ST_EMIT;
          default:      state_nxt = ST_IDLE;
        endcase
        emit_nxt = '0;
      end
      ST_PAD: begin
        phase_nxt = stat.pos_ge56 ? PH_PAD_EXTRA : PH_FINAL;
        state_nxt = ST_LOAD;
      end
      ST_LEN: begin
        phase_nxt = PH_FINAL;
        state_nxt = ST_LOAD;
      end
      ST_EMIT: begin
        emit_nxt = emit_r + 1'b1;
        if (emit_r == LAST_IDX) begin
          emit_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    busy           = (state_r != ST_IDLE);
    cmd.grp        = GRP_CH;
    cmd.emit_idx   = emit_r;
    if (round_r < 7'd20) begin
      cmd.grp = GRP_CH;
    end else if (round_r < 7'd40) begin
      cmd.grp = GRP_PAR1;
    end else if (round_r < 7'd60) begin
      cmd.grp = GRP_MAJ;
    end else begin
      cmd.grp = GRP_PAR2;
    end
    unique case (state_r)
      ST_IDLE:  cmd.write_byte = start && in_has_byte;
      ST_LOAD:  cmd.load       = 1'b1;
      ST_ROUND: cmd.round      = 1'b1;
      ST_ADD:   cmd.add        = 1'b1;
      ST_PAD:   cmd.pad        = 1'b1;
      ST_LEN:   cmd.len_blk    = 1'b1;
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        cmd.finish = (emit_r == LAST_IDX);
      end
      default: cmd.load = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r <= LAST_ROUND))
    else $error("round counter beyond last round");

  a_pad_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD) |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_ADD))
    else $error("padding entered from unexpected state");
`endif

endmodule
`default_nettype wire

### hw/rtl/sha1he_dp.sv
// datapath: block buffer and message schedule, round unit, chaining value and digest output
`default_nettype none
module sha1he_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sha1he_pkg::dp_cmd_t  cmd,
  input  wire logic [7:0]           in_data_byte,
  output sha1he_pkg::dp_stat_t      stat,
  output logic                      out_valid,
  output logic [31:0]               out_digest_word,
  output logic [2:0]                out_word_index,
  output logic                      out_last_word
);
  import sha1he_pkg::*;

  logic [WORD_W-1:0] blk_r   [BLK_WRDS];
  logic [WORD_W-1:0] chain_r [CHAIN_N];
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [POS_W-1:0]  pos_r;
  logic [LEN_W-1:0]  len_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  logic [3:0]        widx;
  logic [BYTE_W-1:0] byte_val;
  logic [63:0]       bit_len;
  logic [WORD_W-1:0] f_val;
  logic [WORD_W-1:0] t_val;
  logic [WORD_W-1:0] sched_x;
  logic [WORD_W-1:0] sched_new;

  assign widx      = pos_r[5:2];
  assign byte_val  = cmd.pad ? PAD_BYTE : in_data_byte;
  assign bit_len   = {len_r, 3'b000};
  assign sched_x   = blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};

  assign stat.pos_full = (pos_r == 6'd63);
  assign stat.pos_ge56 = (pos_r[5:3] == 3'b111);

  always_comb begin
    case (cmd.grp)
      GRP_CH:   f_val = (b_r & c_r) | (~b_r & d_r);
      GRP_MAJ:  f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      default:  f_val = b_r ^ c_r ^ d_r;
    endcase
    t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + K_ROUND[cmd.grp] + blk_r[0];
  end

  // block buffer, doubling as the 16-word schedule window during rounds
  always_ff @(posedge clk) begin
    if (cmd.write_byte || cmd.pad) begin
      case (pos_r[1:0])
        2'd0:    blk_r[widx]        <= {byte_val, 24'h000000};
        2'd1:    blk_r[widx][23:16] <= byte_val;
        2'd2:    blk_r[widx][15:8]  <= byte_val;
        default: blk_r[widx][7:0]   <= byte_val;
      endcase
    end
    if (cmd.pad) begin
      for (int i = 0; i < BLK_WRDS - 2; i++) begin
        if (4'(i) > widx) begin
          blk_r[i] <= '0;
        end
      end
      if (stat.pos_ge56) begin
        if (widx == 4'd14) begin
          blk_r[15] <= '0;
        end
      end else begin
        blk_r[14] <= bit_len[63:32];
        blk_r[15] <= bit_len[31:0];
      end
    end
    if (cmd.len_blk) begin
      for (int i = 0; i < BLK_WRDS - 2; i++) begin
        blk_r[i] <= '0;
      end
      blk_r[14] <= bit_len[63:32];
      blk_r[15] <= bit_len[31:0];
    end
    if (cmd.round) begin
      for (int i = 0; i < BLK_WRDS - 1; i++) begin
        blk_r[i] <= blk_r[i+1];
      end
      blk_r[15] <= sched_new;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // chaining value and message counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_N; i++) begin
        chain_r[i] <= H_INIT[i];
      end
      pos_r <= '0;
      len_r <= '0;
    end else begin
      if (cmd.add) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
        chain_r[4] <= chain_r[4] + e_r;
      end
      if (cmd.write_byte) begin
        pos_r <= pos_r + 1'b1;
        len_r <= len_r + 1'b1;
      end
      if (cmd.finish) begin
        for (int i = 0; i < CHAIN_N; i++) begin
          chain_r[i] <= H_INIT[i];
        end
        pos_r <= '0;
        len_r <= '0;
      end
    end
  end

  // digest output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r <= chain_r[cmd.emit_idx];
      out_idx_r  <= cmd.emit_idx;
      out_last_r <= (cmd.emit_idx == LAST_IDX);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

`ifndef SYNTHESIS
  a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=>
      (out_valid_r && out_idx_r == $past(out_idx_r) + 3'd1))
    else $error("digest words not emitted back to back");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (pos_r == '0 && len_r == '0 && chain_r[0] == H_INIT[0]))
    else $error("message state not cleared after digest");
`endif

endmodule
`default_nettype wire

### hw/rtl/sha1_hash_engine.sv
// sha1 hash engine top level: byte-fed message intake, compression and digest output
// a byte that does not fill a block leaves busy low; a block-filling byte keeps busy high
// while the block is compressed (load, 80 rounds at one per cycle in the shared round unit, add)
// and no byte is taken meanwhile; end of message: the padding block is compressed (preceded by
// the block of a block-filling last byte, followed by a length-only block when the padding needs
// a second block), then the five digest words follow back to back;
// results cannot be stalled; synchronous active-low reset restores the initial chaining value
`default_nettype none
module sha1_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sha1he_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1he_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_has_byte (in_has_byte),
    .in_last     (in_last),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  sha1he_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_data_byte),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule
`default_nettype wire

### dv/sha1_hash_engine_tb.sv
// self-checking testbench for the sha1 hash engine: directed table, then random messages
`default_nettype none
module sha1_hash_engine_tb;
  import sha1he_pkg::*;

  typedef struct packed {
    logic [7:0]   data_b;
    logic         has_b;
    logic         eom;
    logic         known;
    logic [159:0] digest;
  } stim_row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lw;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_last;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  logic [31:0]  chain_h [CHAIN_N];
  logic [31:0]  blk_w [BLK_WRDS];
  logic [5:0]   blk_pos;
  logic [60:0]  msg_len;
  digest_word_t pending_words [$];
  digest_word_t want;
  int           errors;
  bit           gaps_on;
  int           sent;
  stim_row_t    dir_rows [13];

  sha1_hash_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int i;
    for (i = 0; i < 16; i++) w[i] = blk_w[i];
    for (i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_ROUND[0];
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_ROUND[1];
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND[2];
      end else begin
        f = b ^ c ^ d;
        k = K_ROUND[3];
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void store_byte(input logic [5:0] p, input logic [7:0] v);
    if (p[1:0] == 2'd0) blk_w[p[5:2]] = {v, 24'h0};
    else blk_w[p[5:2]] |= {24'h0, v} << ((3 - p[1:0]) * 8);
  endfunction

  function automatic void clear_hash();
    int i;
    for (i = 0; i < CHAIN_N; i++) chain_h[i] = H_INIT[i];
    for (i = 0; i < BLK_WRDS; i++) blk_w[i] = '0;
    blk_pos = '0;
    msg_len = '0;
  endfunction

  // returns 1 when the item closes a message, with the digest in dg
  function automatic bit absorb_item(input logic [7:0] b, input logic h, input logic l,
                                     output logic [159:0] dg);
    logic [6:0]  p;
    logic [63:0] nbits;
    int i;
    dg = '0;
    if (h) begin
      store_byte(blk_pos, b);
      msg_len = msg_len + 61'd1;
      blk_pos = blk_pos + 6'd1;
      if (blk_pos == 6'd0) compress_blk();
    end
    if (!l) return 1'b0;
    p = {1'b0, blk_pos};
    store_byte(blk_pos, PAD_BYTE);
    p = p + 7'd1;
    for (i = (int'(p) + 3) >> 2; i < 16; i++) blk_w[i] = '0;
    if (p > 7'd56) begin
      compress_blk();
      for (i = 0; i < 16; i++) blk_w[i] = '0;
    end
    nbits = {msg_len, 3'b000};
    blk_w[14] = nbits[63:32];
    blk_w[15] = nbits[31:0];
    compress_blk();
    dg = {chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
    clear_hash();
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic h, input logic l,
                           input logic known, input logic [159:0] typed_dg);
    logic [159:0] dg;
    digest_word_t dw;
    int i;
    while (gaps_on && $urandom_range(0, 99) < 28) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start        = 1'b1;
    in_data_byte = b;
    in_has_byte  = h;
    in_last      = l;
    do @(posedge clk); while (busy);
    sent++;
    if (absorb_item(b, h, l, dg)) begin
      if (known) dg = typed_dg;
      for (i = 0; i < CHAIN_N; i++) begin
        dw.word = dg[159 - 32*i -: 32];
        dw.idx  = 3'(i);
        dw.lw   = (3'(i) == LAST_IDX);
        pending_words.push_back(dw);
      end
    end
  endtask

  task automatic send_message(input int len, input bit empty_end);
    int j;
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 99) < 8)
        send_item(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      send_item(8'($urandom), 1'b1, (j == len - 1) && !empty_end, 1'b0, '0);
    end
    if (empty_end || len == 0) begin
      send_item(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $error("unexpected digest transaction: digest_word %h", out_digest_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (out_digest_word !== want.word) begin
          $error("digest_word: expected %h, actual %h", want.word, out_digest_word);
          errors++;
        end
        if (out_word_index !== want.idx) begin
          $error("word_index: expected %0d, actual %0d", want.idx, out_word_index);
          errors++;
        end
        if (out_last_word !== want.lw) begin
          $error("last_word: expected %0d, actual %0d", want.lw, out_last_word);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sha1_hash_engine regression: fail");
    $finish;
  end

  initial begin
    int r, len;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data_byte = '0;
    in_has_byte  = 1'b0;
    in_last      = 1'b0;
    errors       = 0;
    sent         = 0;
    gaps_on      = 1'b1;
    clear_hash();
    dir_rows = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, 160'ha9993e364706816aba3e25717850c26c9cd0d89d},
      '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h5A, 1'b0, 1'b1, 1'b0, 160'h0},
      '{8'hA5, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'h80, 1'b0, 1'b1, 1'b1, 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709},
      '{8'h7F, 1'b1, 1'b1, 1'b0, 160'h0}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].data_b, dir_rows[i].has_b, dir_rows[i].eom,
                dir_rows[i].known, dir_rows[i].digest);

    // random messages, mostly short, the others clustered around the block and padding boundaries
    while (sent < 160) begin
      gaps_on = !(sent >= 50 && sent < 110);
      r = $urandom_range(0, 99);
      if (r < 55) len = $urandom_range(0, 8);
      else if (r < 90) len = $urandom_range(52, 66);
      else len = $urandom_range(118, 130);
      if (len > 160 - sent) len = 160 - sent;
      send_message(len, $urandom_range(0, 3) == 0);
    end
    @(negedge clk);
    start = 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("sha1_hash_engine regression: pass");
    end else begin
      $display("sha1_hash_engine regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
